FILE: design/sdss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdss_pkg
// Shared types, constants and the segment lookup for the signed decimal to
// seven-segment encoder.
// ----------------------------------------------------------------------------
package sdss_pkg;

    localparam int ValueW = 16;
    localparam int MagW   = 14;   // magnitude of an in-range value, max 9999
    localparam int RemW   = 10;   // remainder below 1000
    localparam int Rem2W  = 7;    // remainder below 100
    localparam int DigitW = 4;
    localparam int SegW   = 8;

    localparam logic signed [ValueW-1:0] ValueMax = 16'sd9999;
    localparam logic signed [ValueW-1:0] ValueMin = -16'sd999;

    // Register indexes on the configuration port
    localparam logic CfgColonOn     = 1'b0;
    localparam logic CfgHasPoints   = 1'b1;

    // Point position meaning "no point"
    localparam logic [1:0] PointNone = 2'd3;

    // Digit codes beyond 0..9
    localparam logic [DigitW-1:0] CodeMinus = 4'd10;
    localparam logic [DigitW-1:0] CodeBlank = 4'd11;

    localparam logic [SegW-1:0] PointBit = 8'h80;

    // Flags that travel alongside the digits
    typedef struct packed {
        logic       neg;
        logic       blank;
        logic [1:0] point_digit;
    } sdss_ctrl_t;

    // Segment pattern, bit 0 = a .. bit 6 = g
    function automatic logic [6:0] seg_lookup(input logic [DigitW-1:0] code);
        logic [6:0] pat;
        unique case (code)
            4'd0:      pat = 7'h3f;
            4'd1:      pat = 7'h06;
            4'd2:      pat = 7'h5b;
            4'd3:      pat = 7'h4f;
            4'd4:      pat = 7'h66;
            4'd5:      pat = 7'h6d;
            4'd6:      pat = 7'h7d;
            4'd7:      pat = 7'h07;
            4'd8:      pat = 7'h7f;
            4'd9:      pat = 7'h6f;
            CodeMinus: pat = 7'h40;
            default:   pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

FILE: design/sdss_digit_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdss_digit_split
// Two pipeline stages: thousands digit, then hundreds digit, each by a
// reciprocal multiply and a back-subtract.
// ----------------------------------------------------------------------------
module sdss_digit_split (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  sdss_pkg::sdss_ctrl_t        in_ctrl,
    input  logic [sdss_pkg::MagW-1:0]   in_mag,
    output logic                        out_valid,
    output sdss_pkg::sdss_ctrl_t        out_ctrl,
    output logic [sdss_pkg::DigitW-1:0] out_thou,
    output logic [sdss_pkg::DigitW-1:0] out_hund,
    output logic [sdss_pkg::Rem2W-1:0]  out_rem
);
    import sdss_pkg::*;

    // Stage A: thousands = floor(mag * 8389 / 2^23), exact for mag <= 9999
    logic [26:0]       thou_prod;
    logic [DigitW-1:0] thou_q;
    logic [RemW-1:0]   thou_rem;

    assign thou_prod = {13'd0, in_mag} * 27'd8389;
    assign thou_q    = thou_prod[26:23];
    assign thou_rem  = RemW'(in_mag - MagW'(thou_q) * 14'd1000);

    logic              a_valid_reg;
    sdss_ctrl_t        a_ctrl_reg;
    logic [DigitW-1:0] a_thou_reg;
    logic [RemW-1:0]   a_rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctrl_reg <= in_ctrl;
            a_thou_reg <= thou_q;
            a_rem_reg  <= thou_rem;
        end
    end

    // Stage B: hundreds = floor(rem * 41 / 2^12), exact for rem <= 999
    logic [15:0]       hund_prod;
    logic [DigitW-1:0] hund_q;
    logic [Rem2W-1:0]  hund_rem;

    assign hund_prod = {6'd0, a_rem_reg} * 16'd41;
    assign hund_q    = hund_prod[15:12];
    assign hund_rem  = Rem2W'(a_rem_reg - RemW'(hund_q) * 10'd100);

    logic              b_valid_reg;
    sdss_ctrl_t        b_ctrl_reg;
    logic [DigitW-1:0] b_thou_reg;
    logic [DigitW-1:0] b_hund_reg;
    logic [Rem2W-1:0]  b_rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_ctrl_reg <= a_ctrl_reg;
            b_thou_reg <= a_thou_reg;
            b_hund_reg <= hund_q;
            b_rem_reg  <= hund_rem;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_ctrl  = b_ctrl_reg;
    assign out_thou  = b_thou_reg;
    assign out_hund  = b_hund_reg;
    assign out_rem   = b_rem_reg;

endmodule

FILE: design/sdss_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdss_format
// Two pipeline stages: tens/units split with leading-zero blanking, then the
// segment lookup with colon and decimal point bits.
// ----------------------------------------------------------------------------
module sdss_format (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        colon_on,
    input  logic                        display_has_points,
    input  logic                        in_valid,
    input  sdss_pkg::sdss_ctrl_t        in_ctrl,
    input  logic [sdss_pkg::DigitW-1:0] in_thou,
    input  logic [sdss_pkg::DigitW-1:0] in_hund,
    input  logic [sdss_pkg::Rem2W-1:0]  in_rem,
    output logic                        out_valid,
    output logic [sdss_pkg::SegW-1:0]   out_seg_first,
    output logic [sdss_pkg::SegW-1:0]   out_seg_second,
    output logic [sdss_pkg::SegW-1:0]   out_seg_third,
    output logic [sdss_pkg::SegW-1:0]   out_seg_fourth
);
    import sdss_pkg::*;

    // Stage C: tens = floor(rem * 103 / 2^10), exact for rem <= 99
    logic [13:0]       tens_prod;
    logic [DigitW-1:0] tens_q;
    logic [DigitW-1:0] units;
    logic              blank0;
    logic              blank1;
    logic              blank2;
    logic [DigitW-1:0] code_next [4];

    assign tens_prod = {7'd0, in_rem} * 14'd103;
    assign tens_q    = tens_prod[13:10];
    assign units     = DigitW'(in_rem - Rem2W'(tens_q) * 7'd10);

    // Blanking chain; thousands is always zero for a negative value, so the
    // same chain starts at the second digit there
    assign blank0 = in_ctrl.blank && !in_ctrl.neg && (in_thou == '0);
    assign blank1 = in_ctrl.blank && (in_thou == '0) && (in_hund == '0);
    assign blank2 = blank1 && (tens_q == '0);

    always_comb begin
        code_next[0] = in_ctrl.neg ? CodeMinus : (blank0 ? CodeBlank : in_thou);
        code_next[1] = blank1 ? CodeBlank : in_hund;
        code_next[2] = blank2 ? CodeBlank : tens_q;
        code_next[3] = units;
    end

    logic              c_valid_reg;
    logic [1:0]        c_point_reg;
    logic [DigitW-1:0] c_code_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_point_reg <= in_ctrl.point_digit;
            c_code_reg  <= code_next;
        end
    end

    // Stage D: segment lookup; colon and point each add 0x80 mod 256, and the
    // table never sets bit 7, so the two combine by xor
    logic [SegW-1:0] seg_next [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            seg_next[i] = {colon_on ^ (display_has_points && (c_point_reg != PointNone)
                                       && (c_point_reg == 2'(i))),
                           seg_lookup(c_code_reg[i])};
        end
    end

    logic            d_valid_reg;
    logic [SegW-1:0] d_seg_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_seg_reg <= seg_next;
        end
    end

    assign out_valid      = d_valid_reg;
    assign out_seg_first  = d_seg_reg[0];
    assign out_seg_second = d_seg_reg[1];
    assign out_seg_third  = d_seg_reg[2];
    assign out_seg_fourth = d_seg_reg[3];

endmodule

FILE: design/signed_decimal_to_seven_segment_top.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle; a stall on the result side holds all five
// stages together, and an out-of-range value is dropped in the first stage.
// Reset: synchronous, active low; clears the stage valid bits and both
// configuration registers (colon off, no per-digit points).
// ----------------------------------------------------------------------------
// signed_decimal_to_seven_segment_top
// Five-stage pipeline: range check and magnitude, thousands, hundreds,
// tens/units with blanking, segment lookup with colon and points.
// ----------------------------------------------------------------------------
module signed_decimal_to_seven_segment_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic                               cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sdss_pkg::ValueW-1:0] s_value,
    input  logic                               s_blank_leading,
    input  logic [1:0]                         s_point_digit,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sdss_pkg::SegW-1:0]          m_seg_first,
    output logic [sdss_pkg::SegW-1:0]          m_seg_second,
    output logic [sdss_pkg::SegW-1:0]          m_seg_third,
    output logic [sdss_pkg::SegW-1:0]          m_seg_fourth
);
    import sdss_pkg::*;

    // Configuration registers
    logic colon_on_reg;
    logic has_points_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colon_on_reg   <= 1'b0;
            has_points_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CfgColonOn:   colon_on_reg   <= cfg_data;
                CfgHasPoints: has_points_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances when the output slot is free or being drained
    logic pipe_en;
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    // Stage 1: range check and absolute value
    logic              in_range;
    logic [ValueW-1:0] neg_value;
    sdss_ctrl_t        ctrl_next;

    assign in_range  = (s_value <= ValueMax) && (s_value >= ValueMin);
    assign neg_value = ValueW'(-s_value);

    always_comb begin
        ctrl_next.neg         = s_value[ValueW-1];
        ctrl_next.blank       = s_blank_leading;
        ctrl_next.point_digit = s_point_digit;
    end

    logic            s1_valid_reg;
    sdss_ctrl_t      s1_ctrl_reg;
    logic [MagW-1:0] s1_mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s_valid && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_ctrl_reg <= ctrl_next;
            s1_mag_reg  <= s_value[ValueW-1] ? neg_value[MagW-1:0] : s_value[MagW-1:0];
        end
    end

    // Stages 2 and 3: thousands and hundreds
    logic              sp_valid;
    sdss_ctrl_t        sp_ctrl;
    logic [DigitW-1:0] sp_thou;
    logic [DigitW-1:0] sp_hund;
    logic [Rem2W-1:0]  sp_rem;

    sdss_digit_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s1_valid_reg),
        .in_ctrl   (s1_ctrl_reg),
        .in_mag    (s1_mag_reg),
        .out_valid (sp_valid),
        .out_ctrl  (sp_ctrl),
        .out_thou  (sp_thou),
        .out_hund  (sp_hund),
        .out_rem   (sp_rem)
    );

    // Stages 4 and 5: tens/units, blanking, segments
    sdss_format u_format (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (pipe_en),
        .colon_on           (colon_on_reg),
        .display_has_points (has_points_reg),
        .in_valid           (sp_valid),
        .in_ctrl            (sp_ctrl),
        .in_thou            (sp_thou),
        .in_hund            (sp_hund),
        .in_rem             (sp_rem),
        .out_valid          (m_valid),
        .out_seg_first      (m_seg_first),
        .out_seg_second     (m_seg_second),
        .out_seg_third      (m_seg_third),
        .out_seg_fourth     (m_seg_fourth)
    );

`ifndef SYNTHESIS
    // An out-of-range value never enters the pipeline
    a_drop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !in_range |=> !s1_valid_reg)
        else $error("out-of-range value entered stage 1");

    // An in-range beat always lands in stage 1
    a_take_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && in_range |=> s1_valid_reg)
        else $error("in-range beat lost at stage 1");

    // A stall freezes stage 1
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(s1_valid_reg) && $stable(s1_mag_reg))
        else $error("stage 1 changed during a stall");

    // Magnitude of a live entry stays within four digits
    a_mag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (s1_mag_reg <= 14'd9999))
        else $error("stage 1 magnitude out of range");
`endif

endmodule
